// ===== rtl/sdspi_pkg.sv =====
// sdspi_pkg: types, constants and the crc7 byte step for the sd spi command framer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sdspi_pkg;

	localparam logic [7:0] START_BITS = 8'h40;
	localparam logic [7:0] CMD55_HEAD = 8'h77;
	localparam logic [7:0] FILL_BYTE  = 8'hFF;
	localparam logic [7:0] CRC_TAP    = 8'h12;

	localparam int QUEUE_DEPTH = 2;

	// byte positions within a request: frame a (cmd55), gap, frame b (the command)
	localparam logic [3:0] POS_APP   = 4'd0;
	localparam logic [3:0] POS_PLAIN = 4'd8;
	localparam logic [3:0] POS_GAP   = 4'd7;
	localparam logic [3:0] POS_LAST  = 4'd14;

	// byte offsets within one frame
	localparam logic [2:0] OFS_HEAD = 3'd0;
	localparam logic [2:0] OFS_A3   = 3'd1;
	localparam logic [2:0] OFS_A2   = 3'd2;
	localparam logic [2:0] OFS_A1   = 3'd3;
	localparam logic [2:0] OFS_A0   = 3'd4;
	localparam logic [2:0] OFS_CRC  = 3'd5;
	localparam logic [2:0] OFS_FILL = 3'd6;
	localparam logic [2:0] OFS_GAP  = 3'd7;

	typedef struct packed {
		logic [5:0]  cmd_index;
		logic [31:0] argument;
		logic        app_cmd;
	} req_t;

	typedef struct packed {
		logic [7:0] mosi_byte;
		logic       last_byte;
	} rsp_t;

	// classified request as held in the queue
	typedef struct packed {
		logic [7:0]  head;
		logic [31:0] argument;
		logic [3:0]  start_pos;
	} job_t;

	// crc7 left-aligned in bits 7..1, one byte folded in
	function automatic logic [7:0] crc7_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_TAP) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== rtl/sd_spi_command_framer_core.sv =====
// sd spi command framer: a request word in, 7 bytes out (15 for an application command)
// path: a request goes through the request queue, then the byte sequencer, then the output register
// throughput: one byte per cycle while the output is not stalled, from the byte sequencer in the back part;
// the request queue lets requests follow back to back
// reset: asynchronous, active low; clears the queue, the sequencer and the output valid flag
// depends on sdspi_pkg, sdspi_front, sdspi_back
`timescale 1ns / 1ps

module sd_spi_command_framer_core
	import sdspi_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);

	logic job_valid;
	job_t job;
	logic job_pop;

	sdspi_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.job_valid(job_valid),
		.job      (job),
		.job_pop  (job_pop)
	);

	sdspi_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job      (job),
		.job_pop  (job_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ===== rtl/sdspi_front.sv =====
// sdspi_front: accepts request words, classifies them into jobs and queues them
// depends on sdspi_pkg
`timescale 1ns / 1ps

module sdspi_front
	import sdspi_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic job_valid,
	output job_t job,
	input  logic job_pop
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;
	job_t          job_new;

	assign in_stall  = (count_q == CW'(DEPTH));
	assign job_valid = (count_q != '0);
	assign push      = in_valid && !in_stall;
	assign pop       = job_pop && job_valid;
	assign job       = mem_q[rd_ptr_q];

	always_comb begin
		job_new.head      = {2'b00, in_data.cmd_index} | START_BITS;
		job_new.argument  = in_data.argument;
		job_new.start_pos = in_data.app_cmd ? POS_APP : POS_PLAIN;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sdspi_back.sv =====
// sdspi_back: byte sequencer with running crc7 and the output register
// depends on sdspi_pkg
`timescale 1ns / 1ps

module sdspi_back
	import sdspi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);

	job_t       cur_q;
	logic [3:0] pos_q;
	logic       busy_q;
	logic [7:0] crc_q;
	logic       out_valid_q;
	rsp_t       out_data_q;

	logic       adv;
	logic       emit;
	logic       last;
	logic       in_b;
	logic [2:0] ofs;
	logic [7:0] head;
	logic [31:0] arg;
	logic [7:0] byte_val;
	logic [7:0] crc_d;

	assign adv     = !out_valid_q || !out_stall;
	assign emit    = busy_q && adv;
	assign last    = (pos_q == POS_LAST);
	assign job_pop = job_valid && (!busy_q || (emit && last));

	// positions 0..6 are the cmd55 frame, 7 the gap, 8..14 the command frame
	assign in_b = pos_q[3];
	assign ofs  = (pos_q == POS_GAP) ? OFS_GAP : pos_q[2:0];
	assign head = in_b ? cur_q.head : CMD55_HEAD;
	assign arg  = in_b ? cur_q.argument : 32'h0;

	always_comb begin
		unique case (ofs)
			OFS_HEAD: byte_val = head;
			OFS_A3:   byte_val = arg[31:24];
			OFS_A2:   byte_val = arg[23:16];
			OFS_A1:   byte_val = arg[15:8];
			OFS_A0:   byte_val = arg[7:0];
			OFS_CRC:  byte_val = {crc_q[7:1], 1'b1};
			OFS_FILL: byte_val = FILL_BYTE;
			OFS_GAP:  byte_val = FILL_BYTE;
		endcase
	end

	always_comb begin
		priority if (ofs == OFS_HEAD) begin
			crc_d = crc7_byte(8'h00, byte_val);
		end else if (ofs < OFS_CRC) begin
			crc_d = crc7_byte(crc_q, byte_val);
		end else begin
			crc_d = crc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q <= job;
		end
		if (emit) begin
			crc_q <= crc_d;
			out_data_q.mosi_byte <= byte_val;
			out_data_q.last_byte <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (adv) begin
				out_valid_q <= 1'b0;
			end
			if (job_pop) begin
				busy_q <= 1'b1;
				pos_q  <= job.start_pos;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/sdspi_checker.sv =====
// sdspi_checker: port-level checks on the output word stream of the framer
// depends on sdspi_pkg; bound to sd_spi_command_framer_core
`timescale 1ns / 1ps

module sdspi_checker
	import sdspi_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input rsp_t out_data
);

	logic [3:0] cnt_q;
	logic       take;

	assign take = out_valid && !out_stall;

	// words delivered so far in the current request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= out_data.last_byte ? 4'd0 : cnt_q + 1'b1;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("output word changed while stalled");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		take && out_data.last_byte |-> (cnt_q == 4'd6 || cnt_q == 4'd14))
		else $error("request ended after a wrong number of words");

	a_max: assert property (@(posedge clk) disable iff (!arst_n)
		take && !out_data.last_byte |-> cnt_q < 4'd14)
		else $error("request ran past fifteen words");

	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		take && out_data.last_byte |-> out_data.mosi_byte == FILL_BYTE)
		else $error("final word is not the fill byte");

endmodule

bind sd_spi_command_framer_core sdspi_checker u_chk (.*);
